@@ rtl/core/sfh_pkg.sv @@
// shared types, constants and mixing functions for the superfasthash stream unit
// no dependencies; used by sfh_front, sfh_queue, sfh_back and the top level
package sfh_pkg;

  localparam int WORD_W    = 32;
  localparam int COUNT_W   = 3;
  localparam int LENGTH_W  = 31;
  localparam int IN_DATA_W = 72;  // 32 + 3 + 31 = 66 bits, padded to whole bytes
  localparam int OUT_DATA_W = 32;

  localparam int WORD_LSB   = 0;
  localparam int COUNT_LSB  = WORD_LSB + WORD_W;
  localparam int LENGTH_LSB = COUNT_LSB + COUNT_W;

  // how the back end mixes one word
  typedef enum logic [2:0] {
    KIND_FULL,
    KIND_TAIL3,
    KIND_TAIL2,
    KIND_TAIL1,
    KIND_NONE
  } kind_t;

  typedef struct packed {
    logic [WORD_W-1:0]   word;
    kind_t               kind;
    logic                first;
    logic                last;
    logic                seed_zero;
    logic [LENGTH_W-1:0] seed;
  } q_entry_t;

  function automatic logic [31:0] sext8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  function automatic logic [31:0] block_mix(input logic [31:0] h_in, input logic [31:0] w);
    logic [31:0] h;
    logic [31:0] t;
    h = h_in + {16'h0000, w[15:0]};
    t = ({16'h0000, w[31:16]} << 11) ^ h;
    h = (h << 16) ^ t;
    h = h + (h >> 11);
    return h;
  endfunction

  function automatic logic [31:0] tail_mix(input logic [31:0] h_in, input logic [31:0] w,
                                           input kind_t kind);
    logic [31:0] h;
    h = h_in;
    case (kind)
      KIND_TAIL3: begin
        h = h + {16'h0000, w[15:0]};
        h = h ^ (h << 16);
        h = h ^ (sext8(w[23:16]) << 18);
        h = h + (h >> 11);
      end
      KIND_TAIL2: begin
        h = h + {16'h0000, w[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      KIND_TAIL1: begin
        h = h + sext8(w[7:0]);
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
      default: h = h_in;
    endcase
    return h;
  endfunction

  // avalanche split in three parts, one pipeline stage each
  function automatic logic [31:0] aval_a(input logic [31:0] h_in);
    logic [31:0] h;
    h = h_in ^ (h_in << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    return h;
  endfunction

  function automatic logic [31:0] aval_b(input logic [31:0] h_in);
    logic [31:0] h;
    h = h_in + (h_in >> 17);
    h = h ^ (h << 25);
    return h;
  endfunction

  function automatic logic [31:0] aval_c(input logic [31:0] h_in);
    return h_in + (h_in >> 6);
  endfunction

endpackage

@@ rtl/core/superfasthash_stream_unit.sv @@
// Streaming 32-bit SuperFastHash. Send a message as 32-bit words, byte 0 in bits 7:0;
// s_tuser marks the first word (its total_length seeds the hash), s_tlast the last
// word, whose byte_count may be 0 to 4. One hash per message comes out on m_tdata,
// 0 for a zero-length message. The unit takes one word per clock cycle while its queue is not
// full: the limit is the running-hash update in the back end. A finished hash leaves the
// queue with its last word and then passes the mix register, two avalanche stages and the
// output register, which does the last avalanche step; the QUEUE_DEPTH-entry queue
// absorbs stalls on the output side.
// top level; depends on sfh_pkg, sfh_front, sfh_queue, sfh_back
module superfasthash_stream_unit
  import sfh_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  // [31:0] data_word, [34:32] byte_count, [65:35] total_length, [71:66] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,   // [0] first_item
  input  logic                  s_tlast,   // last_item
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] hash_value
  output logic                  m_tvalid,
  input  logic                  m_tready
);

  logic     push;
  logic     push_ready;
  q_entry_t push_entry;
  logic     pop;
  logic     pop_valid;
  q_entry_t pop_entry;

  sfh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  sfh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop        (pop)
  );

  sfh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop       (pop),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready)
  );

endmodule

@@ rtl/core/sfh_front.sv @@
// input side: unpacks the stream transaction and classifies the word for the back end
// depends on sfh_pkg
module sfh_front
  import sfh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  input  logic                 s_tlast,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 push,
  output q_entry_t             push_entry,
  input  logic                 push_ready
);

  logic [COUNT_W-1:0]  byte_count;
  logic [LENGTH_W-1:0] total_length;
  kind_t               kind;

  assign byte_count   = s_tdata[COUNT_LSB +: COUNT_W];
  assign total_length = s_tdata[LENGTH_LSB +: LENGTH_W];

  // words before the last one are always full blocks; counts above 4 saturate
  always_comb begin
    kind = KIND_FULL;
    if (s_tlast) begin
      unique case (byte_count) inside
        3'd0:          kind = KIND_NONE;
        3'd1:          kind = KIND_TAIL1;
        3'd2:          kind = KIND_TAIL2;
        3'd3:          kind = KIND_TAIL3;
        [3'd4:3'd7]:   kind = KIND_FULL;
        default:       kind = KIND_FULL;
      endcase
    end
  end

  always_comb begin
    push_entry.word      = s_tdata[WORD_LSB +: WORD_W];
    push_entry.kind      = kind;
    push_entry.first     = s_tuser;
    push_entry.last      = s_tlast;
    push_entry.seed_zero = (total_length == '0);
    push_entry.seed      = total_length;
  end

  assign push     = s_tvalid && push_ready;
  assign s_tready = push_ready;

  property p_push_only_on_valid;
    @(posedge clk) disable iff (rst) push |-> s_tvalid && s_tready;
  endproperty
  a_push_only_on_valid: assert property (p_push_only_on_valid)
    else $error("push without an accepted transaction");

  property p_nonlast_is_full;
    @(posedge clk) disable iff (rst) (push && !s_tlast) |-> push_entry.kind == KIND_FULL;
  endproperty
  a_nonlast_is_full: assert property (p_nonlast_is_full)
    else $error("word that is not last classified as tail");

  property p_seed_zero_flag;
    @(posedge clk) disable iff (rst)
      push |-> push_entry.seed_zero == (push_entry.seed == '0);
  endproperty
  a_seed_zero_flag: assert property (p_seed_zero_flag)
    else $error("seed zero flag disagrees with length");

endmodule

@@ rtl/core/sfh_queue.sv @@
// short fifo of classified words between the front and the back end
// depends on sfh_pkg
module sfh_queue
  import sfh_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     push_ready,
  output logic     pop_valid,
  output q_entry_t pop_entry,
  input  logic     pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  q_entry_t        mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_entry  = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CW'(1);
    end else if (pop && !push) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      count <= count_next;
    end
  end

  property p_count_bound;
    @(posedge clk) disable iff (rst) count <= FULL_CNT;
  endproperty
  a_count_bound: assert property (p_count_bound)
    else $error("queue count above depth");

  property p_no_pop_empty;
    @(posedge clk) disable iff (rst) pop |-> pop_valid;
  endproperty
  a_no_pop_empty: assert property (p_no_pop_empty)
    else $error("pop from empty queue");

  property p_no_push_full;
    @(posedge clk) disable iff (rst) push |-> push_ready;
  endproperty
  a_no_push_full: assert property (p_no_push_full)
    else $error("push into full queue");

endmodule

@@ rtl/core/sfh_back.sv @@
// back end: running hash update, three-stage avalanche pipeline and output register
// depends on sfh_pkg
module sfh_back
  import sfh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  input  q_entry_t              pop_entry,
  output logic                  pop,
  output logic [OUT_DATA_W-1:0] m_tdata,  // [31:0] hash_value
  output logic                  m_tvalid,
  input  logic                  m_tready
);

  logic [31:0] running_hash;
  logic        seed_zero;
  logic [31:0] h_base;
  logic        sz_base;
  logic [31:0] h_mix;

  logic        s1_valid, s2_valid, s3_valid;
  logic [31:0] s1_hash, s2_hash, s3_hash;
  logic        s1_zero, s2_zero, s3_zero;
  logic        out_ready, s3_ready, s2_ready, s1_ready;

  assign out_ready = !m_tvalid || m_tready;
  assign s3_ready  = !s3_valid || out_ready;
  assign s2_ready  = !s2_valid || s3_ready;
  assign s1_ready  = !s1_valid || s2_ready;

  // words that are not last only touch the running hash and never wait
  assign pop = pop_valid && (!pop_entry.last || s1_ready);

  always_comb begin
    h_base  = pop_entry.first ? {1'b0, pop_entry.seed} : running_hash;
    sz_base = pop_entry.first ? pop_entry.seed_zero : seed_zero;
    if (pop_entry.kind == KIND_FULL) begin
      h_mix = block_mix(h_base, pop_entry.word);
    end else begin
      h_mix = tail_mix(h_base, pop_entry.word, pop_entry.kind);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      seed_zero    <= 1'b0;
    end else if (pop) begin
      if (pop_entry.last) begin
        running_hash <= '0;
        seed_zero    <= 1'b0;
      end else begin
        running_hash <= h_mix;
        seed_zero    <= sz_base;
      end
    end
  end

  // avalanche pipeline, control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= pop && pop_entry.last;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
      if (out_ready) m_tvalid <= s3_valid;
    end
  end

  // avalanche pipeline, payload
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_hash <= h_mix;
      s1_zero <= sz_base;
    end
    if (s2_ready) begin
      s2_hash <= aval_a(s1_hash);
      s2_zero <= s1_zero;
    end
    if (s3_ready) begin
      s3_hash <= aval_b(s2_hash);
      s3_zero <= s2_zero;
    end
    if (out_ready) begin
      m_tdata <= s3_zero ? '0 : aval_c(s3_hash);
    end
  end

  property p_clear_after_last;
    @(posedge clk) disable iff (rst)
      (pop && pop_entry.last) |=> (running_hash == '0) && !seed_zero;
  endproperty
  a_clear_after_last: assert property (p_clear_after_last)
    else $error("running hash not cleared after last word");

  property p_last_needs_room;
    @(posedge clk) disable iff (rst) (pop && pop_entry.last) |-> s1_ready;
  endproperty
  a_last_needs_room: assert property (p_last_needs_room)
    else $error("last word popped while finalization stalled");

  property p_last_enters_pipe;
    @(posedge clk) disable iff (rst) (pop && pop_entry.last) |=> s1_valid;
  endproperty
  a_last_enters_pipe: assert property (p_last_enters_pipe)
    else $error("last word lost before finalization");

endmodule
